// ===== hdl/fbgs_pkg.sv =====
// Package for the face box gate and select block: types, constants and codes.
// Used by every module of the block; depends on nothing.
package fbgs_pkg;

  localparam int CoordBitsDef = 12;
  localparam int ScoreFracDef = 4;
  localparam int ScoreBits    = 30;
  localparam int CfgBits      = 12;
  localparam int CfgIdxBits   = 3;

  localparam logic [CfgIdxBits-1:0] RegRatioMin  = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegRatioMax  = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegEdge      = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegJump      = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegScale     = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegMinHeight = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegMaxHeight = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATE,
    ST_ROOT,
    ST_SCORE,
    ST_SELECT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic gate;
    logic root_start;
    logic score;
    logic select;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic root_done;
    logic keep;
    logic last;
  } stat_t;

endpackage

// ===== hdl/face_box_gate_and_select_core.sv =====
// Channel  | valid     | stall     | word
// config   | cfg_write | none      | one register write: index and data
// input    | in_valid  | in_stall  | one candidate box with frame and reference data
// output   | out_valid | out_stall | best box of the frame, on the last candidate
// A kept box passes the accepting state, the gate, the square root at one root bit per
// cycle, the penalty and the select. A rejected box is accepted and gated only. The last
// box of a frame then adds the result state, which holds while out_stall is high.
// Reset is synchronous and clears the held box. The result waits in place while
// out_stall is high; no input is taken then.
// Top level of the face box gate and select block; depends on fbgs_pkg,
// fbgs_ctrl and fbgs_datapath.
module face_box_gate_and_select_core
  import fbgs_pkg::*;
#(
  parameter int CoordBits = CoordBitsDef,
  parameter int ScoreFrac = ScoreFracDef
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CfgIdxBits-1:0]       cfg_index,
  input  logic [CfgBits-1:0]          cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [CoordBits:0]   box_x,
  input  logic signed [CoordBits:0]   box_y,
  input  logic signed [CoordBits:0]   box_w,
  input  logic signed [CoordBits:0]   box_h,
  input  logic [9:0]                  det_score_milli,
  input  logic                        is_last,
  input  logic [CoordBits-1:0]        frame_width,
  input  logic [CoordBits-1:0]        frame_height,
  input  logic                        ref_valid,
  input  logic signed [CoordBits:0]   ref_x,
  input  logic signed [CoordBits:0]   ref_y,
  input  logic [CoordBits-1:0]        ref_height,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic signed [CoordBits:0]   best_x,
  output logic signed [CoordBits:0]   best_y,
  output logic [CoordBits-1:0]        best_w,
  output logic [CoordBits-1:0]        best_h,
  output logic signed [ScoreBits-1:0] face_score
);

  ctrl_t ctrl;
  stat_t stat;

  fbgs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .ctrl(ctrl)
  );

  fbgs_datapath #(.CoordBits(CoordBits), .ScoreFrac(ScoreFrac)) u_dp (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .box_x(box_x), .box_y(box_y), .box_w(box_w),
    .box_h(box_h), .det_score_milli(det_score_milli), .is_last(is_last),
    .frame_width(frame_width), .frame_height(frame_height),
    .ref_valid(ref_valid), .ref_x(ref_x), .ref_y(ref_y),
    .ref_height(ref_height), .ctrl(ctrl), .stat(stat), .found(found),
    .best_x(best_x), .best_y(best_y), .best_w(best_w), .best_h(best_h),
    .face_score(face_score)
  );

endmodule

// ===== hdl/fbgs_ctrl.sv =====
// Controller state machine for the face box gate and select block.
// Depends on fbgs_pkg; drives the datapath through ctrl_t and reads stat_t.
module fbgs_ctrl
  import fbgs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_GATE;
      ST_GATE:   state_next = stat.keep ? ST_ROOT : (stat.last ? ST_EMIT : ST_IDLE);
      ST_ROOT:   if (stat.root_done) state_next = ST_SCORE;
      ST_SCORE:  state_next = ST_SELECT;
      ST_SELECT: state_next = stat.last ? ST_EMIT : ST_IDLE;
      ST_EMIT:   if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        ctrl.load = in_valid;
      end
      ST_GATE: begin
        ctrl.gate = 1'b1;
        ctrl.root_start = stat.keep;
      end
      ST_ROOT:   ;
      ST_SCORE:  ctrl.score = 1'b1;
      ST_SELECT: ctrl.select = 1'b1;
      ST_EMIT: begin
        out_valid = 1'b1;
        ctrl.emit = !out_stall;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input taken while a result is shown");
  assert property (@(posedge clk) disable iff (rst) ctrl.load |=> state == ST_GATE)
    else $error("accepted word not gated");
  assert property (@(posedge clk) disable iff (rst) (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

// ===== hdl/fbgs_isqrt.sv =====
// Iterative integer square root, one root bit per cycle through one subtract.
// Imports fbgs_pkg; no other dependency.
module fbgs_isqrt
  import fbgs_pkg::*;
#(
  parameter int InBits = 36
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [InBits-1:0]   value,
  output logic                done,
  output logic [InBits/2-1:0] root
);

  localparam int Steps  = InBits / 2;
  localparam int CntBits = $clog2(Steps + 1);

  logic [InBits-1:0]   rem;
  logic [InBits-1:0]   src;
  logic [InBits/2-1:0] acc;
  logic [CntBits-1:0]  cnt;
  logic                busy;
  logic [InBits/2+1:0] trial;
  logic [InBits/2+1:0] part;

  assign part  = {rem[InBits/2-1:0], src[InBits-1:InBits-2]};
  assign trial = {acc, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntBits'(Steps);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CntBits'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      src <= value;
      acc <= '0;
    end else if (busy) begin
      src <= src << 2;
      if (part >= trial) begin
        rem <= InBits'(part - trial);
        acc <= {acc[InBits/2-2:0], 1'b1};
      end else begin
        rem <= InBits'(part);
        acc <= {acc[InBits/2-2:0], 1'b0};
      end
    end
  end

  assign done = busy && cnt == CntBits'(1);
  assign root = acc;

endmodule

// ===== hdl/fbgs_datapath.sv =====
// Datapath: configuration registers, gating tests, scoring and the held best box.
// Depends on fbgs_pkg and fbgs_isqrt.
module fbgs_datapath
  import fbgs_pkg::*;
#(
  parameter int CoordBits = CoordBitsDef,
  parameter int ScoreFrac = ScoreFracDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [CfgIdxBits-1:0]        cfg_index,
  input  logic [CfgBits-1:0]           cfg_data,
  input  logic signed [CoordBits:0]    box_x,
  input  logic signed [CoordBits:0]    box_y,
  input  logic signed [CoordBits:0]    box_w,
  input  logic signed [CoordBits:0]    box_h,
  input  logic [9:0]                   det_score_milli,
  input  logic                         is_last,
  input  logic [CoordBits-1:0]         frame_width,
  input  logic [CoordBits-1:0]         frame_height,
  input  logic                         ref_valid,
  input  logic signed [CoordBits:0]    ref_x,
  input  logic signed [CoordBits:0]    ref_y,
  input  logic [CoordBits-1:0]         ref_height,
  input  ctrl_t                        ctrl,
  output stat_t                        stat,
  output logic                         found,
  output logic signed [CoordBits:0]    best_x,
  output logic signed [CoordBits:0]    best_y,
  output logic [CoordBits-1:0]         best_w,
  output logic [CoordBits-1:0]         best_h,
  output logic signed [ScoreBits-1:0]  face_score
);

  localparam int SqBits  = 2 * CoordBits + 6;
  localparam int RtIn    = 2 * ((SqBits + 2 * ScoreFrac + 1) / 2);
  localparam int RtBits  = RtIn / 2;
  localparam int WideBits = 48;
  localparam int PenShift = RtBits + 7;
  localparam longint PenRecip = ((64'sd1 <<< PenShift) + 64'sd19) / 64'sd20;
  localparam logic signed [WideBits-1:0] ScoreMax =
    WideBits'((64'sd1 <<< (ScoreBits - 1)) - 64'sd1);

  logic [CfgBits-1:0] ratio_min, ratio_max, edge_m, jump, scale, hmin, hmax;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_min <= 12'd166;
      ratio_max <= 12'd512;
      edge_m    <= 12'd4;
      jump      <= 12'd220;
      scale     <= 12'd410;
      hmin      <= 12'd0;
      hmax      <= 12'd4095;
    end else if (cfg_write) begin
      case (cfg_index)
        RegRatioMin:  ratio_min <= cfg_data;
        RegRatioMax:  ratio_max <= cfg_data;
        RegEdge:      edge_m    <= cfg_data;
        RegJump:      jump      <= cfg_data;
        RegScale:     scale     <= cfg_data;
        RegMinHeight: hmin      <= cfg_data;
        RegMaxHeight: hmax      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [CoordBits:0]   x, y, w, h, rx, ry;
  logic [CoordBits-1:0]        iw, ih, rh;
  logic [9:0]                  milli;
  logic                        last, rv;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x <= box_x; y <= box_y; w <= box_w; h <= box_h;
      milli <= det_score_milli; iw <= frame_width; ih <= frame_height;
      rv <= ref_valid; rx <= ref_x; ry <= ref_y; rh <= ref_height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last <= 1'b0;
    end else if (ctrl.load) begin
      last <= is_last;
    end
  end

  logic signed [WideBits-1:0] xs, ys, ws, hs, rxs, rys, ms, iws, ihs, rhs, dxa, dya;
  logic signed [WideBits-1:0] h256, sc;
  logic                       keep;

  always_comb begin
    xs  = WideBits'(x);  ys = WideBits'(y);
    ws  = WideBits'(w);  hs = WideBits'(h);
    rxs = WideBits'(rx); rys = WideBits'(ry);
    ms  = WideBits'($signed({1'b0, edge_m}));
    iws = WideBits'($signed({1'b0, iw}));
    ihs = WideBits'($signed({1'b0, ih}));
    rhs = WideBits'($signed({1'b0, rh}));
    sc  = WideBits'($signed({1'b0, scale}));
    h256 = hs <<< 8;
    dxa = xs - rxs; if (dxa < 0) dxa = -dxa;
    dya = ys - rys; if (dya < 0) dya = -dya;
    keep = 1'b1;
    if (ws <= 0 || hs <= 0) keep = 1'b0;
    if (h256 < WideBits'($signed({1'b0, ratio_min})) * ws ||
        h256 > WideBits'($signed({1'b0, ratio_max})) * ws) keep = 1'b0;
    if (xs < ms || ys < ms || xs + ws > iws - ms || ys + hs > ihs - ms) keep = 1'b0;
    if (hs < WideBits'($signed({1'b0, hmin})) || hs > WideBits'($signed({1'b0, hmax})))
      keep = 1'b0;
    if (rv) begin
      if (dxa > WideBits'($signed({1'b0, jump})) || dya > WideBits'($signed({1'b0, jump})))
        keep = 1'b0;
      if (rh != '0 && (h256 > sc * rhs || hs * sc < (rhs <<< 8))) keep = 1'b0;
    end
  end

  logic signed [CoordBits+2:0] dx, dy;
  logic [SqBits-1:0]           sq;
  logic [RtIn-1:0]             rt_in;
  logic                        rt_done;
  logic [RtBits-1:0]           root;
  logic [2*CoordBits+1:0]      area;

  assign dx = (CoordBits+3)'(2 * xs + ws - iws);
  assign dy = (CoordBits+3)'(2 * ys + hs - ihs);

  always_ff @(posedge clk) begin
    if (ctrl.gate) begin
      sq   <= SqBits'(dx * dx) + SqBits'(dy * dy);
      area <= (2*CoordBits+2)'(ws * hs);
    end
  end

  assign rt_in = RtIn'(sq) << (2 * ScoreFrac);

  fbgs_isqrt #(.InBits(RtIn)) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.root_start),
    .value (ctrl.root_start ? RtIn'(SqBits'(dx * dx) + SqBits'(dy * dy)) << (2 * ScoreFrac)
                            : rt_in),
    .done  (rt_done),
    .root  (root)
  );

  logic [RtBits+2:0]          pen, pen_num;
  logic [2*RtBits+5:0]        pen_prod;
  logic signed [WideBits-1:0] raw, score;
  logic signed [ScoreBits:0]  cand;

  // The penalty (3r + 10) / 20 is taken by a reciprocal multiply, exact over the root range.
  assign pen_num  = (RtBits+3)'(3 * (RtBits+3)'(root) + 10);
  assign pen_prod = pen_num * (RtBits+3)'(PenRecip);

  always_ff @(posedge clk) begin
    if (ctrl.score) begin
      pen <= (RtBits+3)'(pen_prod >> PenShift);
    end
  end

  always_comb begin
    raw = ((WideBits'(area) + WideBits'(milli)) <<< ScoreFrac) - WideBits'(pen);
    score = raw;
    if (raw > ScoreMax) score = ScoreMax;
    cand = (ScoreBits+1)'(score);
  end

  logic                       have;
  logic signed [ScoreBits:0]  held;
  logic signed [ScoreBits:0]  thr;
  logic signed [CoordBits:0]  hx, hy;
  logic [CoordBits-1:0]       hw, hh;

  assign thr = have ? held : -(ScoreBits+1)'(1 << ScoreFrac);

  always_ff @(posedge clk) begin
    if (rst || ctrl.emit) begin
      have <= 1'b0;
      held <= '0;
      hx <= '0; hy <= '0; hw <= '0; hh <= '0;
    end else if (ctrl.select && cand > thr) begin
      have <= 1'b1;
      held <= cand;
      hx <= x; hy <= y;
      hw <= w[CoordBits-1:0]; hh <= h[CoordBits-1:0];
    end
  end

  logic ok;
  assign ok = have && !held[ScoreBits];
  assign found      = ok;
  assign best_x     = ok ? hx : '0;
  assign best_y     = ok ? hy : '0;
  assign best_w     = ok ? hw : '0;
  assign best_h     = ok ? hh : '0;
  assign face_score = ok ? held[ScoreBits-1:0] : '0;

  assign stat.root_done = rt_done;
  assign stat.keep      = keep;
  assign stat.last      = last;

endmodule
